// ===== rtl/htfd_pkg.sv =====
`default_nettype none

package htfd_pkg;

    // CRC-8 settings used by the sensor for each 16-bit word.
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Scale factors in hundredths: full span of each quantity and the offset; then the divisor.
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUMI_SPAN   = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [16:0] SCALE_DIV   = 17'd65535;

    // Position of the next byte inside the six-byte frame.
    typedef enum logic [2:0] {
        POS_TEMP_MSB = 3'd0,
        POS_TEMP_LSB = 3'd1,
        POS_TEMP_CRC = 3'd2,
        POS_HUMI_MSB = 3'd3,
        POS_HUMI_LSB = 3'd4,
        POS_HUMI_CRC = 3'd5
    } byte_pos_t;

    // One checked frame on its way from the front end to the scaling pipeline.
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] humi_word;
        logic        crc_error;
    } frame_t;

    // Feed one byte into the CRC, most significant bit first.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/htfd_front.sv =====
`default_nettype none

module htfd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_start,
    output logic                 push_valid,
    output htfd_pkg::frame_t     push_data,
    input  wire logic            queue_full
);

    htfd_pkg::byte_pos_t pos_reg, pos_next;
    htfd_pkg::byte_pos_t pos_now;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  crc_now;
    logic [15:0] temp_hold_reg, temp_hold_next;
    logic [15:0] humi_hold_reg, humi_hold_next;
    logic        temp_fail_reg, temp_fail_next;
    logic        accept;

    // Bytes are taken whenever the queue has room for a finished frame.
    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= htfd_pkg::POS_TEMP_MSB;
            crc_reg       <= htfd_pkg::CRC_INIT;
            temp_hold_reg <= '0;
            humi_hold_reg <= '0;
            temp_fail_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_hold_reg <= temp_hold_next;
            humi_hold_reg <= humi_hold_next;
            temp_fail_reg <= temp_fail_next;
        end
    end

    // Byte sequencer: a start flag or a stray count restarts the frame.
    always_comb
    begin
        pos_now = pos_reg;
        crc_now = crc_reg;
        if (in_start || (pos_reg > htfd_pkg::POS_HUMI_CRC))
        begin
            pos_now = htfd_pkg::POS_TEMP_MSB;
            crc_now = htfd_pkg::CRC_INIT;
        end

        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_hold_next = temp_hold_reg;
        humi_hold_next = humi_hold_reg;
        temp_fail_next = temp_fail_reg;
        push_valid     = 1'b0;
        push_data.temp_word = temp_hold_reg;
        push_data.humi_word = humi_hold_reg;
        push_data.crc_error = temp_fail_reg || (crc_now != in_byte);

        if (accept)
        begin
            case (pos_now)
                htfd_pkg::POS_TEMP_MSB:
                begin
                    crc_next       = htfd_pkg::crc_feed(htfd_pkg::CRC_INIT, in_byte);
                    temp_hold_next = {in_byte, temp_hold_reg[7:0]};
                    pos_next       = htfd_pkg::POS_TEMP_LSB;
                end
                htfd_pkg::POS_TEMP_LSB:
                begin
                    crc_next       = htfd_pkg::crc_feed(crc_now, in_byte);
                    temp_hold_next = {temp_hold_reg[15:8], in_byte};
                    pos_next       = htfd_pkg::POS_TEMP_CRC;
                end
                htfd_pkg::POS_TEMP_CRC:
                begin
                    temp_fail_next = (crc_now != in_byte);
                    crc_next       = htfd_pkg::CRC_INIT;
                    pos_next       = htfd_pkg::POS_HUMI_MSB;
                end
                htfd_pkg::POS_HUMI_MSB:
                begin
                    crc_next       = htfd_pkg::crc_feed(crc_now, in_byte);
                    humi_hold_next = {in_byte, humi_hold_reg[7:0]};
                    pos_next       = htfd_pkg::POS_HUMI_LSB;
                end
                htfd_pkg::POS_HUMI_LSB:
                begin
                    crc_next       = htfd_pkg::crc_feed(crc_now, in_byte);
                    humi_hold_next = {humi_hold_reg[15:8], in_byte};
                    pos_next       = htfd_pkg::POS_HUMI_CRC;
                end
                htfd_pkg::POS_HUMI_CRC:
                begin
                    push_valid = 1'b1;
                    crc_next   = htfd_pkg::CRC_INIT;
                    pos_next   = htfd_pkg::POS_TEMP_MSB;
                end
                default:
                begin
                    pos_next = htfd_pkg::POS_TEMP_MSB;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/htfd_queue.sv =====
`default_nettype none

module htfd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    input  wire htfd_pkg::frame_t  push_data,
    output logic                   full,
    output logic                   pop_valid,
    output htfd_pkg::frame_t       pop_data,
    input  wire logic              pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    htfd_pkg::frame_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/htfd_back.sv =====
`default_nettype none

module htfd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire htfd_pkg::frame_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [14:0]     temp_centi,
    output logic [13:0]            humi_centi,
    output logic [15:0]            temp_word,
    output logic [15:0]            humi_word,
    output logic                   crc_error
);

    // Stage 1: scaled products.
    logic              s1_valid_reg, s1_valid_next;
    logic [30:0]       temp_prod_reg, temp_prod_next;
    logic [29:0]       humi_prod_reg, humi_prod_next;
    htfd_pkg::frame_t  s1_frame_reg;
    logic              s1_ready;

    // Stage 2: quotients and output register.
    logic              out_valid_reg, out_valid_next;
    logic [14:0]       temp_centi_reg, temp_centi_next;
    logic [13:0]       humi_centi_reg, humi_centi_next;
    htfd_pkg::frame_t  out_frame_reg;
    logic              out_free;

    logic [14:0]       temp_q_est;
    logic [16:0]       temp_rem;
    logic [14:0]       temp_q;
    logic [13:0]       humi_q_est;
    logic [16:0]       humi_rem;
    logic [13:0]       humi_q;

    // A stage moves on when the one after it is empty or emptying.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || out_free;
    assign in_ready = s1_ready;

    assign temp_prod_next = 31'(in_data.temp_word) * 31'(htfd_pkg::TEMP_SPAN);
    assign humi_prod_next = 30'(in_data.humi_word) * 30'(htfd_pkg::HUMI_SPAN);

    // Divide by 65535: the quotient by 65536 is low by at most one, and the
    // remainder against 65535 is the low half plus that quotient.
    always_comb
    begin
        temp_q_est = temp_prod_reg[30:16];
        temp_rem   = {1'b0, temp_prod_reg[15:0]} + {2'b00, temp_q_est};
        temp_q     = temp_q_est + 15'(temp_rem >= htfd_pkg::SCALE_DIV);
        humi_q_est = humi_prod_reg[29:16];
        humi_rem   = {1'b0, humi_prod_reg[15:0]} + {3'b000, humi_q_est};
        humi_q     = humi_q_est + 14'(humi_rem >= htfd_pkg::SCALE_DIV);
        temp_centi_next = 15'({1'b0, temp_q} - htfd_pkg::TEMP_OFFSET);
        humi_centi_next = humi_q;
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = in_valid;
        end
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load only on a transfer into their stage.
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            temp_prod_reg <= temp_prod_next;
            humi_prod_reg <= humi_prod_next;
            s1_frame_reg  <= in_data;
        end
        if (out_free && s1_valid_reg)
        begin
            temp_centi_reg <= temp_centi_next;
            humi_centi_reg <= humi_centi_next;
            out_frame_reg  <= s1_frame_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign temp_centi = $signed(temp_centi_reg);
    assign humi_centi = humi_centi_reg;
    assign temp_word  = out_frame_reg.temp_word;
    assign humi_word  = out_frame_reg.humi_word;
    assign crc_error  = out_frame_reg.crc_error;

endmodule

`default_nettype wire

// ===== rtl/humidity_temperature_frame_decode_core.sv =====
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] rx_byte, tuser frame_start
// m_axis    out        tdata temp_centi, humi_centi, temp_word, humi_word; tuser crc_error
//
// One byte is taken per cycle while the queue is not full; the CRC is updated as each byte is taken.
// A result passes from its sixth byte through the queue, the product stage and the
// divide-by-65535 stage with the output register.
// Reset clears the byte count, CRC, hold words, queue and pipeline valids.
// A stalled output backs up the pipeline and then the queue; the input stalls
// only when the queue is full.
`default_nettype none

module humidity_temperature_frame_decode_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [14:0] temp_centi, [28:15] humi_centi, [44:29] temp_word,
    // [60:45] humi_word, [63:61] zero
    output logic [63:0]      m_tdata,
    output logic             m_tuser    // [0] crc_error
);

    logic              push_valid;
    htfd_pkg::frame_t  push_data;
    logic              queue_full;
    logic              pop_valid;
    htfd_pkg::frame_t  pop_data;
    logic              pop_ready;
    logic signed [14:0] temp_centi;
    logic [13:0]       humi_centi;
    logic [15:0]       temp_word;
    logic [15:0]       humi_word;

    htfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_start   (s_tuser),
        .push_valid (push_valid),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    htfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    htfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pop_valid),
        .in_ready   (pop_ready),
        .in_data    (pop_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .temp_centi (temp_centi),
        .humi_centi (humi_centi),
        .temp_word  (temp_word),
        .humi_word  (humi_word),
        .crc_error  (m_tuser)
    );

    assign m_tdata = {3'b000, humi_word, temp_word, humi_centi, temp_centi};

endmodule

`default_nettype wire

// ===== rtl/htfd_checker.sv =====
`default_nettype none

module htfd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output changed while stalled");

    // Humidity never leaves its scaled range.
    a_humi_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[28:15] <= 14'd10000))
        else $error("humidity out of range");

    // Temperature never leaves its scaled range.
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (($signed(m_tdata[14:0]) >= -15'sd4500)
                   && ($signed(m_tdata[14:0]) <= 15'sd13000)))
        else $error("temperature out of range");

    // The padding bits stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[63:61] == 3'b000))
        else $error("padding bits set");

    // After an idle input cycle the input side still stalls only on a full queue:
    // a ready input never drops without an input transfer.
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && !s_tvalid) |=> s_tready)
        else $error("input ready dropped without a transfer");

endmodule

bind humidity_temperature_frame_decode_core htfd_checker u_htfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
